FILE: hw/rtl/tefc_pkg.sv
package tefc_pkg;

  localparam int unsigned RawWidth = 64;
  localparam int unsigned ResWidth = 32;
  localparam int unsigned SrcFmtWidth = 4;
  localparam int unsigned DstFmtWidth = 3;
  localparam int unsigned Bf16Shift = 16;

  typedef enum logic [SrcFmtWidth-1:0] {
    SRC_F32  = 4'd0,
    SRC_F16  = 4'd1,
    SRC_BF16 = 4'd2,
    SRC_F64  = 4'd3,
    SRC_I64  = 4'd4,
    SRC_I32  = 4'd5,
    SRC_I16  = 4'd6,
    SRC_I8   = 4'd7,
    SRC_U8   = 4'd8,
    SRC_BOOL = 4'd9
  } src_fmt_e;

  typedef enum logic [DstFmtWidth-1:0] {
    DST_F32  = 3'd0,
    DST_F16  = 3'd1,
    DST_BF16 = 3'd2,
    DST_I32  = 3'd3,
    DST_I16  = 3'd4,
    DST_I8   = 3'd5
  } dst_fmt_e;

  typedef enum logic [0:0] {
    CFG_SRC = 1'b0,
    CFG_DST = 1'b1
  } cfg_idx_e;

  // Result of the conversion datapath handed to the output stage.
  typedef struct packed {
    logic [ResWidth-1:0] data;
    logic                bad;
  } conv_res_t;

  // Round-to-nearest-even decision: guard bit, sticky, lsb.
  function automatic logic rne_up(input logic lsb, input logic guard, input logic sticky);
    return guard & (sticky | lsb);
  endfunction

endpackage

FILE: hw/rtl/tefc_f64_f32.sv
module tefc_f64_f32 (
  input  logic [63:0] x_i,
  output logic [31:0] y_o
);
  import tefc_pkg::*;

  logic        s;
  logic [10:0] e;
  logic [51:0] m;
  logic signed [12:0] ef;
  logic [6:0]  sh;   // extra right shift for subnormal results
  logic [52:0] sig;
  logic [52:0] shifted;
  logic        sticky_lo;
  logic [23:0] q;
  logic [24:0] qr;
  logic        g, st;
  logic [31:0] mag;

  always_comb begin
    s   = x_i[63];
    e   = x_i[62:52];
    m   = x_i[51:0];
    sig = {1'b1, m};
    ef  = $signed({2'b00, e}) - 13'sd896;
    sh  = 7'd0;
    if (ef < 13'sd1) begin
      sh = (ef < -13'sd40) ? 7'd60 : 7'(13'sd1 - ef);
    end
    // Right shift by sh, collect the bits dropped into sticky.
    shifted   = sig >> sh;
    sticky_lo = |(sig & ~({53{1'b1}} << sh));
    q   = shifted[52:29];
    g   = shifted[28];
    st  = (|shifted[27:0]) | sticky_lo;
    qr  = {1'b0, q} + 25'(rne_up(q[0], g, st));
    if (ef >= 13'sd1) begin
      mag = ({24'd0, 8'(ef - 13'sd1)} << 23) + {7'd0, qr};
    end else begin
      mag = {7'd0, qr};
    end
    if (ef >= 13'sd255 || mag >= 32'h7F80_0000) mag = 32'h7F80_0000;
    if (e == 11'h7FF) begin
      mag = (m == '0) ? 32'h7F80_0000 : (32'h7FC0_0000 | {9'd0, m[51:29]});
    end else if (e == '0) begin
      mag = '0;
    end
    y_o = {s, 31'd0} | mag;
  end
endmodule

FILE: hw/rtl/tefc_f32_f16.sv
module tefc_f32_f16 (
  input  logic [31:0] x_i,
  output logic [15:0] y_o
);
  import tefc_pkg::*;

  logic       s;
  logic [7:0] e;
  logic [22:0] m;
  logic signed [9:0] ef;
  logic [5:0] sh;
  logic [23:0] sig, shifted;
  logic       sticky_lo, g, st;
  logic [10:0] q;
  logic [15:0] mag, qr;

  always_comb begin
    s   = x_i[31];
    e   = x_i[30:23];
    m   = x_i[22:0];
    sig = {1'b1, m};
    ef  = $signed({2'b00, e}) - 10'sd112;
    sh  = 6'd0;
    if (ef < 10'sd1) sh = (ef < -10'sd30) ? 6'd31 : 6'(10'sd1 - ef);
    shifted   = sig >> sh;
    sticky_lo = |(sig & ~({24{1'b1}} << sh));
    q   = shifted[23:13];
    g   = shifted[12];
    st  = (|shifted[11:0]) | sticky_lo;
    qr  = {5'd0, q} + 16'(rne_up(q[0], g, st));
    if (ef >= 10'sd1) mag = ({11'd0, 5'(ef - 10'sd1)} << 10) + qr;
    else mag = qr;
    if (ef >= 10'sd31 || mag >= 16'h7C00) mag = 16'h7C00;
    if (e == 8'hFF) mag = (m == '0) ? 16'h7C00 : 16'h7E00;
    else if (e == '0) mag = '0;
    y_o = {s, 15'd0} | mag;
  end
endmodule

FILE: hw/rtl/tefc_f16_f32.sv
module tefc_f16_f32 (
  input  logic [15:0] x_i,
  output logic [31:0] y_o
);
  import tefc_pkg::*;

  logic       s;
  logic [4:0] e;
  logic [9:0] m;
  logic [3:0] p;
  logic [22:0] frac;

  always_comb begin
    s = x_i[15];
    e = x_i[14:10];
    m = x_i[9:0];
    // Leading one search over ten bits for subnormal inputs.
    p = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) p = 4'(i);
    end
    frac = 23'({13'd0, m} << (5'd23 - {1'b0, p}));
    if (e == 5'h1F) begin
      y_o = {s, 8'hFF, m, 13'd0};
    end else if (e == '0) begin
      if (m == '0) y_o = {s, 31'd0};
      else y_o = {s, 8'({4'd0, p} + 8'd103), frac};
    end else begin
      y_o = {s, 8'({3'd0, e} + 8'd112), m, 13'd0};
    end
  end
endmodule

FILE: hw/rtl/tensor_element_format_converter.sv
// Tensor element converter: one raw element word in, one converted word out.
// Set source_format (index 0) and dest_format (index 1) while idle. Supported
// pairs are F64->F32 and F32->F16 (round to nearest even), F16->F32 (exact),
// BF16->F32, I64->I32, BOOL->I8, U8->I8 and same-type copies; any other pair
// returns zero with bad_pair_o set. Words pass an input register, then a
// result register; a new word is accepted every cycle, limited only by the
// output register draining.
module tensor_element_format_converter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [tefc_pkg::SrcFmtWidth-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tefc_pkg::RawWidth-1:0]    raw_element_i,
  input  logic                             is_last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [tefc_pkg::ResWidth-1:0]    converted_element_o,
  output logic                             bad_pair_o,
  output logic                             last_out_o
);
  import tefc_pkg::*;

  logic [SrcFmtWidth-1:0] src_q;
  logic [DstFmtWidth-1:0] dst_q;

  // Stage 1: input register.
  logic                s1_valid_q;
  logic [RawWidth-1:0] s1_raw_q;
  logic                s1_last_q;
  logic                s1_adv;

  // Stage 2: result register.
  logic      s2_valid_q;
  conv_res_t s2_res_q, s2_res_d;
  logic      s2_last_q;

  logic [31:0] f64_f32, f16_f32;
  logic [15:0] f32_f16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
      dst_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_SRC) src_q <= cfg_data_i;
      else dst_q <= cfg_data_i[DstFmtWidth-1:0];
    end
  end

  // Advance stage 1 into stage 2 when the result register is free or draining.
  assign s1_adv     = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s1_adv) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_raw_q  <= raw_element_i;
      s1_last_q <= is_last_i;
    end
    if (s1_adv && s1_valid_q) begin
      s2_res_q  <= s2_res_d;
      s2_last_q <= s1_last_q;
    end
  end

  tefc_f64_f32 u_f64_f32 (.x_i(s1_raw_q), .y_o(f64_f32));
  tefc_f32_f16 u_f32_f16 (.x_i(s1_raw_q[31:0]), .y_o(f32_f16));
  tefc_f16_f32 u_f16_f32 (.x_i(s1_raw_q[15:0]), .y_o(f16_f32));

  // Select by type pair; anything unlisted flags the word.
  always_comb begin
    s2_res_d = '{data: '0, bad: 1'b0};
    case ({src_q, dst_q})
      {SRC_F32, DST_F32}:   s2_res_d.data = s1_raw_q[31:0];
      {SRC_F16, DST_F16}:   s2_res_d.data = {16'd0, s1_raw_q[15:0]};
      {SRC_BF16, DST_BF16}: s2_res_d.data = {16'd0, s1_raw_q[15:0]};
      {SRC_F64, DST_F32}:   s2_res_d.data = f64_f32;
      {SRC_F32, DST_F16}:   s2_res_d.data = {16'd0, f32_f16};
      {SRC_F16, DST_F32}:   s2_res_d.data = f16_f32;
      {SRC_BF16, DST_F32}:  s2_res_d.data = {s1_raw_q[15:0], 16'd0};
      {SRC_I64, DST_I32}:   s2_res_d.data = s1_raw_q[31:0];
      {SRC_I32, DST_I32}:   s2_res_d.data = s1_raw_q[31:0];
      {SRC_I16, DST_I16}:   s2_res_d.data = {16'd0, s1_raw_q[15:0]};
      {SRC_I8, DST_I8}:     s2_res_d.data = {24'd0, s1_raw_q[7:0]};
      {SRC_U8, DST_I8}:     s2_res_d.data = {24'd0, s1_raw_q[7:0]};
      {SRC_BOOL, DST_I8}:   s2_res_d.data = {31'd0, |s1_raw_q[7:0]};
      default:              s2_res_d.bad  = 1'b1;
    endcase
  end

  assign out_valid_o         = s2_valid_q;
  assign converted_element_o = s2_res_q.data;
  assign bad_pair_o          = s2_res_q.bad;
  assign last_out_o          = s2_last_q;

  // Hold the result while the sink stalls.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(converted_element_o))
    else $error("result changed under stall");
  // A bad word always carries zero data.
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_pair_o |-> converted_element_o == '0)
    else $error("bad pair with nonzero data");
  // A staged word moves on unless the result register is stuck.
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !in_ready_o |-> s2_valid_q && !out_ready_i)
    else $error("pipeline stalled without back-pressure");
endmodule

FILE: bench/tensor_element_format_converter_tb.sv
module tensor_element_format_converter_tb;
  import tefc_pkg::*;

  typedef struct {
    logic [3:0]  src;
    logic [2:0]  dst;
    logic [63:0] raw;
    logic        last;
    logic        typed;   // expected word typed in below
    logic [31:0] res;
    logic        bad;
  } row_t;

  typedef struct {
    logic [31:0] data;
    logic        bad;
    logic        last;
  } word_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic                   cfg_idx_i = 1'b0;
  logic [SrcFmtWidth-1:0] cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [RawWidth-1:0]    raw_element_i = '0;
  logic                   is_last_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [ResWidth-1:0]    converted_element_o;
  logic                   bad_pair_o;
  logic                   last_out_o;

  // Bench copy of the two format registers.
  logic [3:0] src_fmt_q = 4'd0;
  logic [2:0] dst_fmt_q = 3'd0;

  word_t       expected_words[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          sink_enabled = 1'b0;
  localparam int unsigned CycleLimit = 400000;

  tensor_element_format_converter uut (.*);

  always #2 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatch_count++;
  endtask

  // Round v >> sh to nearest even.
  function automatic logic [63:0] shift_rne(input logic [63:0] v, input int sh);
    logic [63:0] q, rem, half;
    q = v >> sh;
    rem = v & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q++;
    return q;
  endfunction

  // Pack a normalized significand into a narrower float's magnitude.
  function automatic logic [31:0] pack_magnitude(input logic [63:0] sig, input int ef,
                                                 input int drop, input int mbits,
                                                 input int emax);
    logic [63:0] base, r, inf_code;
    int sh;
    inf_code = 64'(emax) << mbits;
    if (ef >= emax) return 32'(inf_code);
    if (ef >= 1) begin
      base = 64'(ef - 1) << mbits;
      sh = drop;
    end else begin
      if (1 - ef > 40) return 32'd0;
      base = 0;
      sh = drop + 1 - ef;
    end
    if (sh >= 64) return 32'd0;
    r = base + shift_rne(sig, sh);
    if (r >= inf_code) return 32'(inf_code);
    return 32'(r);
  endfunction

  function automatic logic [31:0] narrow_f64(input logic [63:0] x);
    logic [31:0] s;
    s = {x[63], 31'd0};
    if (x[62:52] == 11'h7FF)
      return (x[51:0] == 0) ? (s | 32'h7F800000) : (s | 32'h7FC00000 | 32'(x[51:29]));
    if (x[62:52] == 0) return s;
    return s | pack_magnitude({11'd1, x[51:0]}, int'(x[62:52]) - 896, 29, 23, 255);
  endfunction

  function automatic logic [31:0] narrow_f32(input logic [31:0] x);
    logic [31:0] s;
    s = {16'd0, x[31], 15'd0};
    if (x[30:23] == 8'hFF) return (x[22:0] == 0) ? (s | 32'h7C00) : (s | 32'h7E00);
    if (x[30:23] == 0) return s;
    return s | pack_magnitude({40'd0, 1'b1, x[22:0]}, int'(x[30:23]) - 112, 13, 10, 31);
  endfunction

  function automatic logic [31:0] widen_f16(input logic [15:0] x);
    logic [31:0] s;
    int p;
    s = {x[15], 31'd0};
    if (x[14:10] == 5'd31) return s | 32'h7F800000 | (32'(x[9:0]) << 13);
    if (x[14:10] == 0) begin
      if (x[9:0] == 0) return s;
      p = 9;
      while (!x[p]) p--;
      return s | (32'(p + 103) << 23) | ((32'(x[9:0]) << (23 - p)) & 32'h7FFFFF);
    end
    return s | (32'(x[14:10] + 112) << 23) | (32'(x[9:0]) << 13);
  endfunction

  function automatic word_t convert_element(input logic [63:0] raw, input logic last);
    word_t w;
    w.data = 32'd0;
    w.bad = 1'b0;
    w.last = last;
    case ({src_fmt_q, 1'b0, dst_fmt_q})
      {SRC_F32, 1'b0, DST_F32}, {SRC_I64, 1'b0, DST_I32},
      {SRC_I32, 1'b0, DST_I32}:  w.data = raw[31:0];
      {SRC_F16, 1'b0, DST_F16}, {SRC_BF16, 1'b0, DST_BF16},
      {SRC_I16, 1'b0, DST_I16}:  w.data = {16'd0, raw[15:0]};
      {SRC_F64, 1'b0, DST_F32}:  w.data = narrow_f64(raw);
      {SRC_F32, 1'b0, DST_F16}:  w.data = narrow_f32(raw[31:0]);
      {SRC_F16, 1'b0, DST_F32}:  w.data = widen_f16(raw[15:0]);
      {SRC_BF16, 1'b0, DST_F32}: w.data = {raw[15:0], 16'd0};
      {SRC_I8, 1'b0, DST_I8}, {SRC_U8, 1'b0, DST_I8}: w.data = {24'd0, raw[7:0]};
      {SRC_BOOL, 1'b0, DST_I8}:  w.data = {31'd0, raw[7:0] != 0};
      default:                   w.bad = 1'b1;
    endcase
    return w;
  endfunction

  // Drive one register write and advance past its edge; the caller drops the enable.
  task automatic write_format(input cfg_idx_e idx, input logic [3:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == CFG_SRC) src_fmt_q = value;
    else dst_fmt_q = value[2:0];
  endtask

  task automatic set_pair(input logic [3:0] src, input logic [2:0] dst);
    write_format(CFG_SRC, src);
    write_format(CFG_DST, {1'b0, dst});
    cfg_we_i <= 1'b0;
  endtask

  // Let the pipe drain before touching the registers.
  task automatic wait_idle();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1) : $urandom_range(2, 20);
  endfunction

  // Wait a random gap with valid low, then hold the word until the handshake; valid stays high on return.
  task automatic send_word(input logic [63:0] raw, input logic last, input word_t want);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_element_i <= raw;
    is_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    expected_words.push_back(want);
  endtask

  function automatic logic [63:0] random_raw();
    logic [63:0] v;
    int k;
    v = {$urandom, $urandom};
    k = $urandom_range(0, 9);
    // Push exponents toward the interesting edges, or clear the low byte.
    case (k)
      0: v[62:52] = 11'h7FF;
      1: v[62:52] = 11'd0;
      2: v[62:52] = 11'(896 + $urandom_range(0, 40) - 20);
      3: v[62:52] = 11'(1150 + $urandom_range(0, 10));
      4: v[30:23] = 8'hFF;
      5: v[30:23] = 8'(112 + $urandom_range(0, 24) - 12);
      6: v[14:10] = 5'($urandom_range(0, 1) ? 31 : 0);
      7: v[7:0] = 8'd0;
      default: ;
    endcase
    return v;
  endfunction

  // Accept result words with random stalls and compare against the oldest one.
  always @(posedge clk_i) begin
    word_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", converted_element_o, 32'd0);
      end else begin
        want = expected_words.pop_front();
        if (converted_element_o !== want.data)
          report_mismatch("converted_element", converted_element_o, want.data);
        if (bad_pair_o !== want.bad)
          report_mismatch("bad_pair", 32'(bad_pair_o), 32'(want.bad));
        if (last_out_o !== want.last)
          report_mismatch("last_out", 32'(last_out_o), 32'(want.last));
      end
    end
    if (sink_enabled) out_ready_i <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 19) == 0);
  end

  row_t rows[$];
  word_t want;

  initial begin
    rows = '{
      // reset pair F32 copy: full width, upper bits dropped
      '{SRC_F32, DST_F32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{SRC_F32, DST_F32, 64'd0, 1'b1, 1'b1, 32'd0, 1'b0},
      // F64 to F32: infinity, NaN, overflow, zero-exponent input, rounding
      '{SRC_F64, DST_F32, 64'h7FF0_0000_0000_0000, 1'b0, 1'b1, 32'h7F80_0000, 1'b0},
      '{SRC_F64, DST_F32, 64'hFFF0_0000_0000_0001, 1'b0, 1'b0, 32'd0, 1'b0},
      '{SRC_F64, DST_F32, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'h7F80_0000, 1'b0},
      '{SRC_F64, DST_F32, 64'h800F_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
      '{SRC_F64, DST_F32, 64'h3FF0_0000_1000_0000, 1'b1, 1'b0, 32'd0, 1'b0},
      '{SRC_F64, DST_F32, 64'h3690_0000_0000_0001, 1'b0, 1'b0, 32'd0, 1'b0},
      // F32 to F16: NaN, infinity, overflow, underflow to subnormal
      '{SRC_F32, DST_F16, 64'h0000_0000_FFC1_2345, 1'b0, 1'b1, 32'h0000_FE00, 1'b0},
      '{SRC_F32, DST_F16, 64'h0000_0000_7F80_0000, 1'b0, 1'b1, 32'h0000_7C00, 1'b0},
      '{SRC_F32, DST_F16, 64'h0000_0000_477F_F000, 1'b0, 1'b0, 32'd0, 1'b0},
      '{SRC_F32, DST_F16, 64'h0000_0000_3380_0001, 1'b0, 1'b0, 32'd0, 1'b0},
      '{SRC_F32, DST_F16, 64'hFFFF_FFFF_807F_FFFF, 1'b1, 1'b1, 32'h0000_8000, 1'b0},
      // F16 to F32: subnormal, NaN payload
      '{SRC_F16, DST_F32, 64'hFFFF_FFFF_FFFF_0001, 1'b0, 1'b1, 32'h3380_0000, 1'b0},
      '{SRC_F16, DST_F32, 64'h0000_0000_0000_7DFF, 1'b0, 1'b0, 32'd0, 1'b0},
      '{SRC_BF16, DST_F32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_0000, 1'b0},
      '{SRC_I64, DST_I32, 64'h8000_0000_7FFF_FFFF, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{SRC_BOOL, DST_I8, 64'hFFFF_FFFF_FFFF_FF00, 1'b0, 1'b1, 32'd0, 1'b0},
      '{SRC_BOOL, DST_I8, 64'h0000_0000_0000_0080, 1'b0, 1'b1, 32'd1, 1'b0},
      '{SRC_U8, DST_I8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'h0000_00FF, 1'b0},
      '{SRC_I16, DST_I16, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'h0000_FFFF, 1'b0},
      // unsupported pairs, codes above the listed range included
      '{SRC_I8, DST_F32, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 32'd0, 1'b1},
      '{4'd15, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 32'd0, 1'b1},
      '{4'd10, DST_I8, 64'h1234, 1'b0, 1'b1, 32'd0, 1'b1}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    sink_enabled = 1'b1;

    // Walk the directed table; reconfigure only when the pair changes.
    foreach (rows[i]) begin
      if (i == 0 || rows[i].src != src_fmt_q || rows[i].dst != dst_fmt_q) begin
        in_valid_i <= 1'b0;
        wait_idle();
        set_pair(rows[i].src, rows[i].dst);
      end
      want = convert_element(rows[i].raw, rows[i].last);
      if (rows[i].typed) begin
        want.data = rows[i].res;
        want.bad = rows[i].bad;
      end
      send_word(rows[i].raw, rows[i].last, want);
    end

    // Random phases: mostly supported pairs, some bad ones.
    for (int phase = 0; phase < 31; phase++) begin
      logic [3:0] s;
      logic [2:0] d;
      int pick;
      in_valid_i <= 1'b0;
      wait_idle();
      pick = $urandom_range(0, 15);
      case (pick)
        0: begin s = SRC_F32; d = DST_F32; end
        1: begin s = SRC_F16; d = DST_F16; end
        2: begin s = SRC_BF16; d = DST_BF16; end
        3, 13: begin s = SRC_F64; d = DST_F32; end
        4, 14: begin s = SRC_F32; d = DST_F16; end
        5: begin s = SRC_F16; d = DST_F32; end
        6: begin s = SRC_BF16; d = DST_F32; end
        7: begin s = SRC_I64; d = DST_I32; end
        8: begin s = SRC_I32; d = DST_I32; end
        9: begin s = SRC_I16; d = DST_I16; end
        10: begin s = SRC_I8; d = DST_I8; end
        11: begin s = SRC_U8; d = DST_I8; end
        12: begin s = SRC_BOOL; d = DST_I8; end
        default: begin s = 4'($urandom); d = 3'($urandom); end
      endcase
      if (phase == 0) begin s = 4'd15; d = 3'd7; end
      if (phase == 1) begin s = 4'd0; d = 3'd0; end
      set_pair(s, d);
      for (int n = 0; n < 50; n++) begin
        logic [63:0] raw;
        logic last;
        raw = random_raw();
        last = ($urandom_range(0, 7) == 0);
        send_word(raw, last, convert_element(raw, last));
        // Hold off once mid-run until the pipe is empty.
        if (phase == 15 && n == 25) begin
          in_valid_i <= 1'b0;
          while (expected_words.size() != 0) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
